[src/hsg_pkg.sv]
// ----------------------------------------------------------------------------
// hsg_pkg
// Types and constants shared by the sound generator top level and its tone
// channels: transaction payloads, action codes, register indexes and the
// fixed-point constants of the phase accumulators.
// ----------------------------------------------------------------------------
package hsg_pkg;

    // action codes of an input transaction
    localparam logic [1:0] ACT_WRITE    = 2'd0;
    localparam logic [1:0] ACT_SAMPLE   = 2'd1;
    localparam logic [1:0] ACT_LEN_TICK = 2'd2;

    // register indexes on reg_select
    localparam logic [3:0] REG_DMA_START_LO = 4'd8;
    localparam logic [3:0] REG_DMA_START_HI = 4'd9;
    localparam logic [3:0] REG_DMA_LENGTH   = 4'd10;
    localparam logic [3:0] REG_DMA_CTRL     = 4'd11;
    localparam logic [3:0] REG_DMA_ENABLE   = 4'd12;
    localparam logic [3:0] REG_NOISE_RATE   = 4'd13;
    localparam logic [3:0] REG_NOISE_TIMER  = 4'd14;
    localparam logic [3:0] REG_NOISE_MODE   = 4'd15;

    // tone register offsets within a channel
    localparam logic [1:0] TONE_PER_LO = 2'd0;
    localparam logic [1:0] TONE_PER_HI = 2'd1;
    localparam logic [1:0] TONE_CTRL   = 2'd2;
    localparam logic [1:0] TONE_TIMER  = 2'd3;

    // duty codes
    localparam logic [1:0] DUTY_28 = 2'd0;
    localparam logic [1:0] DUTY_24 = 2'd1;
    localparam logic [1:0] DUTY_16 = 2'd2;
    localparam logic [1:0] DUTY_9  = 2'd3;

    // step = STEP_NUM / (rate * (1 + k)), 16 fraction bits
    localparam longint unsigned STEP_NUM   = 64'd1024000000;
    localparam int              STEP_CODES = 16;

    // tone length = period * rate / LEN_DIV, via a reciprocal with LEN_SHIFT bits
    localparam longint unsigned LEN_DIV   = 64'd125000;
    localparam int              LEN_SHIFT = 28;

    // bank window of the dma address space
    localparam logic [15:0] BANK_WIN_LO = 16'h8000;
    localparam logic [15:0] BANK_WIN_HI = 16'hC000;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] dma_byte;
    } t_in_item;

    typedef struct packed {
        logic [13:0] left_sample;
        logic [13:0] right_sample;
        logic [16:0] dma_fetch_address;
        logic        dma_busy;
        logic        dma_irq;
    } t_out_item;

    typedef struct packed {
        logic       wr;
        logic [1:0] offset;
        logic [7:0] data;
        logic       sample;
        logic       len_tick;
    } t_tone_ctl;

endpackage

[src/hsg_tone.sv]
// ----------------------------------------------------------------------------
// hsg_tone
// One pulse-tone channel: period registers, length derived from the period,
// duty comparison, volume and length timer.
// ----------------------------------------------------------------------------
module hsg_tone #(
    parameter int OUT_RATE_HZ = 44100
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsg_pkg::t_tone_ctl i_ctl,
    output logic [11:0]       o_level
);
    import hsg_pkg::*;

    // ceil(rate * 2^LEN_SHIFT / LEN_DIV), exact for 11-bit periods
    localparam longint unsigned LEN_MULT =
        ((longint'(OUT_RATE_HZ) << LEN_SHIFT) + LEN_DIV - 64'd1) / LEN_DIV;
    localparam logic [27:0] LEN_MULT_W = 28'(LEN_MULT);

    logic [7:0]  r_per_lo;
    logic [2:0]  r_per_hi;
    logic        r_enable;
    logic [1:0]  r_duty;
    logic [3:0]  r_vol;
    logic [10:0] r_pos;
    logic [10:0] r_len;
    logic [8:0]  r_timer;

    logic [10:0] w_per;
    logic [38:0] w_prod;
    logic [10:0] w_len_new;
    logic [15:0] w_th_wide;
    logic [10:0] w_th;
    logic [11:0] w_pos_inc;
    logic        w_on;

    always_comb begin
        if (i_ctl.offset == TONE_PER_LO) begin
            w_per = {r_per_hi, i_ctl.data};
        end else begin
            w_per = {i_ctl.data[2:0], r_per_lo};
        end
    end

    assign w_prod    = 39'(w_per) * 39'(LEN_MULT_W);
    assign w_len_new = w_prod[38:28];

    always_comb begin
        case (r_duty)
            DUTY_28: w_th_wide = (16'(r_len) * 16'd28) >> 5;
            DUTY_24: w_th_wide = (16'(r_len) * 16'd24) >> 5;
            DUTY_16: w_th_wide = 16'(r_len) >> 1;
            DUTY_9:  w_th_wide = (16'(r_len) * 16'd9) >> 5;
            default: w_th_wide = 16'd0;
        endcase
    end

    assign w_th      = w_th_wide[10:0];
    assign w_on      = (r_pos <= w_th);
    assign w_pos_inc = 12'(r_pos) + 12'd1;

    assign o_level = ((r_len != 11'd0) && (r_enable || (r_timer != 9'd0)) && w_on)
                   ? {r_vol, 8'h00} : 12'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per_lo <= 8'd0;
            r_per_hi <= 3'd0;
            r_enable <= 1'b0;
            r_duty   <= 2'd0;
            r_vol    <= 4'd0;
            r_pos    <= 11'd0;
            r_len    <= 11'd0;
            r_timer  <= 9'd0;
        end else if (i_ctl.wr) begin
            case (i_ctl.offset)
                TONE_PER_LO: begin
                    r_per_lo <= i_ctl.data;
                    r_len    <= w_len_new;
                    r_pos    <= 11'd0;
                end
                TONE_PER_HI: begin
                    r_per_hi <= i_ctl.data[2:0];
                    r_len    <= w_len_new;
                    r_pos    <= 11'd0;
                end
                TONE_CTRL: begin
                    r_enable <= i_ctl.data[6];
                    r_duty   <= i_ctl.data[5:4];
                    r_vol    <= i_ctl.data[3:0];
                end
                default: begin
                    r_timer <= 9'(i_ctl.data) + 9'd1;
                end
            endcase
        end else if (i_ctl.sample) begin
            if (r_len != 11'd0) begin
                if (w_pos_inc >= 12'(r_len)) begin
                    r_pos <= 11'd0;
                end else begin
                    r_pos <= w_pos_inc[10:0];
                end
            end
        end else if (i_ctl.len_tick) begin
            if (r_timer != 9'd0) begin
                r_timer <= r_timer - 9'd1;
            end
        end
    end

`ifndef ASSERT_OFF
    // position stays inside the period
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos < r_len) || (r_pos == 11'd0))
        else $error("tone position outside the period");

    a_timer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer <= 9'd256)
        else $error("tone timer above its load value");

    // a period write always restarts the waveform
    a_period_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.wr && (i_ctl.offset == TONE_PER_LO || i_ctl.offset == TONE_PER_HI))
        |=> (r_pos == 11'd0))
        else $error("period write did not restart the tone");
`endif

endmodule

[src/handheld_sound_generator_unit.sv]
// ----------------------------------------------------------------------------
// handheld_sound_generator_unit
// Sound unit with two pulse tones, an LFSR noise channel and a nibble dma
// player, mixed to left and right on every sample tick.
// Input channel (i_valid / o_ready / i_data) carries one transaction per
// register write, sample tick or length tick; the output channel
// (o_valid / i_ready / o_data) returns exactly one result per transaction.
// A transaction is registered at acceptance and its result is registered in
// the output register, computed by the single-pass update logic between the
// two registers; throughput one transaction per cycle while the receiver does not stall.
// dma_fetch_address and dma_busy show the state after the transaction in
// the output register; the memory byte at that address goes with the next
// sample tick as dma_byte.
// Synchronous reset clears every channel and empties both registers.
// When the receiver stalls the result is held and the block stops taking
// input once its input register is also full; nothing is lost.
// ----------------------------------------------------------------------------
module handheld_sound_generator_unit #(
    parameter int OUT_RATE_HZ = 44100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hsg_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output hsg_pkg::t_out_item o_data
);
    import hsg_pkg::*;

    // step table for noise and dma rates
    logic [16:0] w_step_tab [STEP_CODES];
    for (genvar k = 0; k < STEP_CODES; k++) begin : g_step
        localparam longint unsigned STEP_K =
            STEP_NUM / (longint'(OUT_RATE_HZ) * longint'(k + 1));
        assign w_step_tab[k] = 17'(STEP_K);
    end

    // handshake and pipeline registers
    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    logic [13:0] r_out_left;
    logic [13:0] r_out_right;
    logic        r_out_irq;
    logic        w_move;

    // noise state
    logic [3:0]  r_noise_vol;
    logic [16:0] r_noise_step;
    logic [8:0]  r_noise_timer;
    logic [4:0]  r_noise_mode;
    logic [13:0] r_noise_lfsr;
    logic [16:0] r_noise_phase;
    logic        r_noise_out;

    // dma state
    logic [15:0] r_dma_start;
    logic [13:0] r_dma_length;
    logic [16:0] r_dma_step;
    logic [1:0]  r_dma_route;
    logic [2:0]  r_dma_bank;
    logic        r_dma_enable;
    logic [29:0] r_dma_phase;

    logic        w_wr;
    logic        w_sample;
    logic        w_len_tick;
    t_tone_ctl   w_tone_ctl [2];
    logic [11:0] w_tone_lvl [2];

    logic        w_noise_active;
    logic [11:0] w_noise_lvl;
    logic [17:0] w_nsum;
    logic [16:0] w_nsat;
    logic        w_ntop;
    logic        w_nnxt;
    logic [3:0]  w_nib;
    logic [29:0] w_dphase;
    logic        w_dend;
    logic [13:0] w_left;
    logic [13:0] w_right;
    logic [15:0] w_addr;
    logic [16:0] w_fetch;

    assign w_move  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_move;

    assign w_wr       = w_move && (r_in.action == ACT_WRITE);
    assign w_sample   = w_move && (r_in.action == ACT_SAMPLE);
    assign w_len_tick = w_move && (r_in.action == ACT_LEN_TICK);

    for (genvar c = 0; c < 2; c++) begin : g_tone
        assign w_tone_ctl[c].wr       = w_wr && !r_in.reg_select[3]
                                      && (r_in.reg_select[2] == 1'(c));
        assign w_tone_ctl[c].offset   = r_in.reg_select[1:0];
        assign w_tone_ctl[c].data     = r_in.write_data;
        assign w_tone_ctl[c].sample   = w_sample;
        assign w_tone_ctl[c].len_tick = w_len_tick;

        hsg_tone #(
            .OUT_RATE_HZ (OUT_RATE_HZ)
        ) u_tone (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_tone_ctl[c]),
            .o_level (w_tone_lvl[c])
        );
    end

    // noise channel
    assign w_noise_active = r_noise_mode[4] && (r_noise_mode[1] || (r_noise_timer != 9'd0));
    assign w_noise_lvl    = r_noise_out ? {r_noise_vol, 8'h00} : 12'd0;
    assign w_nsum         = 18'(r_noise_phase) + 18'(r_noise_step);
    assign w_nsat         = w_nsum[17] ? 17'h1FFFF : w_nsum[16:0];
    assign w_ntop         = r_noise_mode[0] ? r_noise_lfsr[13] : r_noise_lfsr[6];
    assign w_nnxt         = r_noise_mode[0] ? r_noise_lfsr[12] : r_noise_lfsr[5];

    // dma player, high nibble on even nibble index
    assign w_nib    = r_dma_phase[16] ? r_in.dma_byte[3:0] : r_in.dma_byte[7:4];
    assign w_dphase = r_dma_phase + 30'(r_dma_step);
    assign w_dend   = (w_dphase >= {r_dma_length, 16'h0000});

    always_comb begin
        w_left  = 14'(w_tone_lvl[1]);
        w_right = 14'(w_tone_lvl[0]);
        if (w_noise_active && r_noise_mode[3]) begin
            w_left = w_left + 14'(w_noise_lvl);
        end
        if (w_noise_active && r_noise_mode[2]) begin
            w_right = w_right + 14'(w_noise_lvl);
        end
        if (r_dma_enable && r_dma_route[1]) begin
            w_left = w_left + {2'b00, w_nib, 8'h00};
        end
        if (r_dma_enable && r_dma_route[0]) begin
            w_right = w_right + {2'b00, w_nib, 8'h00};
        end
    end

    // state only changes when a transaction enters the output register, so the
    // address below always belongs to the result on display
    assign w_addr = r_dma_start + 16'(r_dma_phase[29:17]);
    always_comb begin
        if ((w_addr >= BANK_WIN_LO) && (w_addr < BANK_WIN_HI)) begin
            w_fetch = {r_dma_bank, w_addr[13:0]};
        end else begin
            w_fetch = {1'b0, w_addr};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = '{left_sample:       r_out_left,
                       right_sample:      r_out_right,
                       dma_fetch_address: w_fetch,
                       dma_busy:          r_dma_enable,
                       dma_irq:           r_out_irq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
        if (w_move) begin
            r_out_left  <= w_sample ? w_left : 14'd0;
            r_out_right <= w_sample ? w_right : 14'd0;
            r_out_irq   <= w_sample && r_dma_enable && w_dend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_vol   <= 4'd0;
            r_noise_step  <= 17'd0;
            r_noise_timer <= 9'd0;
            r_noise_mode  <= 5'd0;
            r_noise_lfsr  <= 14'd0;
            r_noise_phase <= 17'd0;
            r_noise_out   <= 1'b0;
            r_dma_start   <= 16'd0;
            r_dma_length  <= 14'd0;
            r_dma_step    <= 17'd0;
            r_dma_route   <= 2'd0;
            r_dma_bank    <= 3'd0;
            r_dma_enable  <= 1'b0;
            r_dma_phase   <= 30'd0;
        end else if (w_wr) begin
            if (r_in.reg_select inside {[REG_NOISE_RATE:REG_NOISE_MODE]}) begin
                r_noise_phase <= 17'd0;
            end
            case (r_in.reg_select)
                REG_DMA_START_LO: r_dma_start[7:0]  <= r_in.write_data;
                REG_DMA_START_HI: r_dma_start[15:8] <= r_in.write_data;
                REG_DMA_LENGTH: begin
                    // zero means the longest length, 4096 bytes
                    r_dma_length <= (r_in.write_data == 8'd0)
                                  ? {9'h100, 5'd0} : {1'b0, r_in.write_data, 5'd0};
                end
                REG_DMA_CTRL: begin
                    r_dma_step  <= w_step_tab[{2'b00, r_in.write_data[1:0]}];
                    r_dma_route <= r_in.write_data[3:2];
                    r_dma_bank  <= r_in.write_data[6:4];
                end
                REG_DMA_ENABLE: begin
                    r_dma_enable <= r_in.write_data[7];
                    if (r_in.write_data[7]) begin
                        r_dma_phase <= 30'd0;
                    end
                end
                REG_NOISE_RATE: begin
                    r_noise_vol  <= r_in.write_data[3:0];
                    r_noise_step <= w_step_tab[r_in.write_data[7:4]];
                end
                REG_NOISE_TIMER: r_noise_timer <= 9'(r_in.write_data) + 9'd1;
                REG_NOISE_MODE: begin
                    r_noise_mode <= r_in.write_data[4:0];
                    r_noise_lfsr <= 14'd1;
                end
                default: ;
            endcase
        end else if (w_sample) begin
            if (w_noise_active) begin
                if (w_nsat[16]) begin
                    r_noise_out   <= w_ntop;
                    r_noise_lfsr  <= {r_noise_lfsr[12:0], w_ntop ^ w_nnxt};
                    r_noise_phase <= {1'b0, w_nsat[15:0]};
                end else begin
                    r_noise_phase <= w_nsat;
                end
            end
            if (r_dma_enable) begin
                r_dma_phase <= w_dphase;
                if (w_dend) begin
                    r_dma_enable <= 1'b0;
                end
            end
        end else if (w_len_tick) begin
            if (r_noise_timer != 9'd0) begin
                r_noise_timer <= r_noise_timer - 9'd1;
            end
        end
    end

`ifndef ASSERT_OFF
    // the end-of-block interrupt comes with playback already stopped
    a_irq_stops_dma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_irq) |-> !r_dma_enable)
        else $error("dma interrupt while playback still enabled");

    // noise phase is always below one whole unit after wrap
    a_noise_phase_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_noise_phase[16])
        else $error("noise phase not wrapped");

    // playback only starts through a register write
    a_dma_start_by_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_dma_enable) |-> $past(w_move && (r_in.action == ACT_WRITE)))
        else $error("dma enabled without a register write");

    // a non-sample result carries silence and no interrupt
    a_silent_non_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && (r_in.action != ACT_SAMPLE))
        |=> (r_out_left == 14'd0) && (r_out_right == 14'd0) && !r_out_irq)
        else $error("non-sample transaction produced output");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sound generator against a transaction-level predictor of its
// tone, noise and dma channels: register writes, sample ticks, length ticks
// and the unused action go in, and every result is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
    import hsg_pkg::*;

    localparam int              SAMPLE_HZ      = 44100;
    localparam longint unsigned STEP_DIVIDEND  = 64'd1024000000;
    localparam longint unsigned TONE_REF_HZ    = 64'd4000000;
    localparam int unsigned     PHASE_ONE      = 32'h10000;
    localparam int unsigned     PHASE_MAX      = 32'h1FFFF;
    localparam logic [1:0]      ACT_UNUSED     = 2'd3;
    localparam int              WATCHDOG_LIMIT = 200;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    handheld_sound_generator_unit #(
        .OUT_RATE_HZ(SAMPLE_HZ)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // predicted channel state
    logic [7:0]  period_byte    [4] = '{default: '0};
    logic        tone_en        [2] = '{default: '0};
    logic [1:0]  tone_duty_code [2] = '{default: '0};
    logic [3:0]  tone_vol       [2] = '{default: '0};
    logic [15:0] tone_pos       [2] = '{default: '0};
    logic [15:0] tone_len       [2] = '{default: '0};
    logic [8:0]  tone_tmr       [2] = '{default: '0};
    logic [3:0]  nz_vol   = '0;
    logic [16:0] nz_step  = '0;
    logic [8:0]  nz_tmr   = '0;
    logic [4:0]  nz_mode  = '0;
    logic [13:0] nz_lfsr  = '0;
    logic [16:0] nz_phase = '0;
    logic        nz_bit   = 1'b0;
    logic [15:0] dm_start = '0;
    logic [13:0] dm_len   = '0;
    logic [16:0] dm_step  = '0;
    logic [1:0]  dm_route = '0;
    logic [2:0]  dm_bank  = '0;
    logic        dm_on    = 1'b0;
    logic [29:0] dm_phase = '0;
    logic [16:0] last_fetch = '0;

    logic [7:0] mem_image [0:131071];

    t_out_item pending_mix [$];
    int        mismatch_count = 0;
    bit        idle_on = 1'b1;
    t_out_item want_mix;
    int        rx_hold = 0;
    int        rx_gap;
    int        quiet_cycles = 0;

    function automatic logic [16:0] rate_step(input logic [3:0] code);
        longint unsigned q;
        q = STEP_DIVIDEND / (longint'(SAMPLE_HZ) * (longint'(code) + 1));
        return q[16:0];
    endfunction

    // tone 0 owns the first four selects, tone 1 the next four
    function automatic logic [3:0] tone_reg(input logic ch, input logic [1:0] off);
        return {1'b0, ch, off};
    endfunction

    function automatic t_out_item next_mix(input t_in_item item);
        t_out_item   res;
        int unsigned lsum, rsum, acc, lim, snd;
        logic        top_tap, next_tap, irq;
        logic [3:0]  nib;
        logic [10:0] per;
        logic [15:0] addr;
        int          ch;
        lsum = 0;
        rsum = 0;
        irq  = 1'b0;
        case (item.action)
            ACT_WRITE: begin
                if (item.reg_select < REG_DMA_START_LO) begin
                    ch = item.reg_select[2];
                    case (item.reg_select[1:0])
                        TONE_PER_LO, TONE_PER_HI: begin
                            period_byte[ch * 2 + item.reg_select[0]] = item.write_data;
                            per = {period_byte[ch * 2 + 1][2:0], period_byte[ch * 2]};
                            tone_len[ch] = 16'((longint'(SAMPLE_HZ) * (longint'(per) << 5))
                                               / TONE_REF_HZ);
                            tone_pos[ch] = '0;
                        end
                        TONE_CTRL: begin
                            tone_en[ch]        = item.write_data[6];
                            tone_duty_code[ch] = item.write_data[5:4];
                            tone_vol[ch]       = item.write_data[3:0];
                        end
                        default: tone_tmr[ch] = {1'b0, item.write_data} + 9'd1;
                    endcase
                end else begin
                    case (item.reg_select)
                        REG_DMA_START_LO: dm_start[7:0]  = item.write_data;
                        REG_DMA_START_HI: dm_start[15:8] = item.write_data;
                        REG_DMA_LENGTH: begin
                            // zero stands for the longest length, 4096 bytes
                            if (item.write_data == 8'h00) dm_len = 14'd8192;
                            else dm_len = {1'b0, item.write_data, 5'b00000};
                        end
                        REG_DMA_CTRL: begin
                            dm_step  = rate_step({2'b00, item.write_data[1:0]});
                            dm_route = item.write_data[3:2];
                            dm_bank  = item.write_data[6:4];
                        end
                        REG_DMA_ENABLE: begin
                            dm_on = item.write_data[7];
                            if (dm_on) dm_phase = '0;
                        end
                        REG_NOISE_RATE: begin
                            nz_vol  = item.write_data[3:0];
                            nz_step = rate_step(item.write_data[7:4]);
                        end
                        REG_NOISE_TIMER: nz_tmr = {1'b0, item.write_data} + 9'd1;
                        default: begin
                            nz_mode = item.write_data[4:0];
                            nz_lfsr = 14'd1;
                        end
                    endcase
                    if (item.reg_select >= REG_NOISE_RATE) nz_phase = '0;
                end
            end
            ACT_SAMPLE: begin
                for (ch = 0; ch < 2; ch++) begin
                    // a zero-length tone is silent and its position holds
                    if (tone_len[ch] != 0) begin
                        if (tone_en[ch] || tone_tmr[ch] != 0) begin
                            case (tone_duty_code[ch])
                                DUTY_28: lim = (28 * tone_len[ch]) >> 5;
                                DUTY_24: lim = (24 * tone_len[ch]) >> 5;
                                DUTY_16: lim = tone_len[ch] >> 1;
                                default: lim = (9 * tone_len[ch]) >> 5;
                            endcase
                            snd = (tone_pos[ch] <= lim) ? {tone_vol[ch], 8'h00} : 0;
                            if (ch == 0) rsum += snd;
                            else lsum += snd;
                        end
                        tone_pos[ch] = tone_pos[ch] + 16'd1;
                        if (tone_pos[ch] >= tone_len[ch]) tone_pos[ch] = '0;
                    end
                end
                if (nz_mode[4] && (nz_mode[1] || nz_tmr != 0)) begin
                    snd = nz_bit ? {nz_vol, 8'h00} : 0;
                    if (nz_mode[3]) lsum += snd;
                    if (nz_mode[2]) rsum += snd;
                    acc = nz_phase + nz_step;
                    if (acc > PHASE_MAX) acc = PHASE_MAX;
                    if (acc >= PHASE_ONE) begin
                        top_tap  = nz_mode[0] ? nz_lfsr[13] : nz_lfsr[6];
                        next_tap = nz_mode[0] ? nz_lfsr[12] : nz_lfsr[5];
                        nz_bit   = top_tap;
                        nz_lfsr  = {nz_lfsr[12:0], top_tap ^ next_tap};
                        acc -= PHASE_ONE;
                    end
                    nz_phase = acc[16:0];
                end
                if (dm_on) begin
                    // high nibble first
                    nib = dm_phase[16] ? item.dma_byte[3:0] : item.dma_byte[7:4];
                    if (dm_route[1]) lsum += {nib, 8'h00};
                    if (dm_route[0]) rsum += {nib, 8'h00};
                    dm_phase = dm_phase + dm_step;
                    if (dm_phase >= {dm_len, 16'h0000}) begin
                        dm_on = 1'b0;
                        irq   = 1'b1;
                    end
                end
            end
            ACT_LEN_TICK: begin
                for (ch = 0; ch < 2; ch++)
                    if (tone_tmr[ch] != 0) tone_tmr[ch] = tone_tmr[ch] - 9'd1;
                if (nz_tmr != 0) nz_tmr = nz_tmr - 9'd1;
            end
            default: ;
        endcase
        addr = dm_start + 16'(dm_phase >> 17);
        if (addr >= BANK_WIN_LO && addr < BANK_WIN_HI) last_fetch = {dm_bank, addr[13:0]};
        else last_fetch = {1'b0, addr};
        res.left_sample       = lsum[13:0];
        res.right_sample      = rsum[13:0];
        res.dma_fetch_address = last_fetch;
        res.dma_busy          = dm_on;
        res.dma_irq           = irq;
        return res;
    endfunction

    // one transaction on the input side; the memory byte follows the last fetch address
    task automatic send_item(input logic [1:0] act, input logic [3:0] sel,
                             input logic [7:0] val);
        t_in_item item;
        int       gap;
        item.action     = act;
        item.reg_select = sel;
        item.write_data = val;
        item.dma_byte   = mem_image[last_fetch];
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_mix.push_back(next_mix(item));
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [3:0] sel, input logic [7:0] val);
        send_item(ACT_WRITE, sel, val);
    endtask

    task automatic tick(input int count);
        repeat (count) send_item(ACT_SAMPLE, 4'($urandom), 8'($urandom));
    endtask

    task automatic test_directed();
        idle_on = 1'b0;
        tick(1);
        send_item(ACT_UNUSED, 4'hF, 8'hFF);
        // no length written yet: playback ends on the first tick
        write_reg(REG_DMA_ENABLE, 8'h80);
        tick(1);
        write_reg(tone_reg(1'b0, TONE_PER_LO), 8'hFF);
        write_reg(tone_reg(1'b0, TONE_PER_HI), 8'hFF);
        write_reg(tone_reg(1'b0, TONE_CTRL), 8'h7F);
        // period of one rounds to a zero length
        write_reg(tone_reg(1'b1, TONE_PER_LO), 8'h01);
        write_reg(tone_reg(1'b1, TONE_CTRL), 8'h4F);
        tick(2);
        // disabled tone kept alive by its length timer until it runs out
        write_reg(tone_reg(1'b1, TONE_PER_LO), 8'h10);
        write_reg(tone_reg(1'b1, TONE_CTRL), 8'h2F);
        write_reg(tone_reg(1'b1, TONE_TIMER), 8'h00);
        tick(1);
        send_item(ACT_LEN_TICK, 4'h0, 8'h00);
        tick(1);
        write_reg(REG_NOISE_RATE, 8'hFF);
        write_reg(REG_NOISE_MODE, 8'h1F);
        tick(2);
        write_reg(REG_DMA_START_LO, 8'hFF);
        write_reg(REG_DMA_START_HI, 8'h9F);
        write_reg(REG_DMA_LENGTH, 8'h01);
        write_reg(REG_DMA_CTRL, 8'h7F);
        write_reg(REG_DMA_ENABLE, 8'h80);
        tick(2);
    endtask

    task automatic test_tones();
        for (int round = 0; round < 5; round++) begin
            idle_on = (round % 2) == 0;
            for (int ch = 0; ch < 2; ch++) begin
                write_reg(tone_reg(1'(ch), TONE_PER_LO), 8'($urandom));
                write_reg(tone_reg(1'(ch), TONE_PER_HI),
                          ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
                write_reg(tone_reg(1'(ch), TONE_CTRL), 8'($urandom));
                write_reg(tone_reg(1'(ch), TONE_TIMER), 8'($urandom_range(0, 30)));
            end
            repeat (70) begin
                if ($urandom_range(0, 9) == 0) send_item(ACT_LEN_TICK, 4'($urandom), 8'($urandom));
                else tick(1);
            end
        end
    endtask

    task automatic test_noise();
        idle_on = 1'b1;
        for (int round = 0; round < 5; round++) begin
            write_reg(REG_NOISE_RATE,
                      {(round == 4) ? 4'hF : 4'($urandom_range(0, 3)), 4'($urandom)});
            write_reg(REG_NOISE_TIMER, 8'($urandom_range(0, 40)));
            write_reg(REG_NOISE_MODE,
                      8'($urandom) | (($urandom_range(0, 3) != 0) ? 8'h10 : 8'h00));
            repeat (60) begin
                if ($urandom_range(0, 6) == 0) send_item(ACT_LEN_TICK, 4'($urandom), 8'($urandom));
                else tick(1);
            end
        end
    endtask

    task automatic test_dma_playback();
        int guard;
        for (int round = 0; round < 8; round++) begin
            idle_on = (round % 3) != 1;
            write_reg(REG_DMA_START_LO, 8'($urandom));
            write_reg(REG_DMA_START_HI, 8'($urandom));
            // one full-size block, cut short further down
            write_reg(REG_DMA_LENGTH, (round == 5) ? 8'h00 : 8'h01);
            write_reg(REG_DMA_CTRL, 8'(($urandom & 32'hFC) | $urandom_range(0, 1)));
            write_reg(REG_DMA_ENABLE, 8'($urandom) | 8'h80);
            guard = 0;
            while (dm_on) begin
                case ($urandom_range(0, 19))
                    0:       send_item(ACT_LEN_TICK, 4'($urandom), 8'($urandom));
                    1:       write_reg(tone_reg(1'($urandom), 2'($urandom)), 8'($urandom));
                    2:       write_reg(REG_NOISE_MODE, 8'($urandom));
                    default: tick(1);
                endcase
                guard++;
                if (round == 5 && guard == 60) write_reg(REG_DMA_ENABLE, 8'($urandom) & 8'h7F);
            end
            tick(2);
        end
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < 300; n++) begin
            if (n % 50 == 0) idle_on = 1'($urandom);
            send_item(2'($urandom), 4'($urandom), 8'($urandom));
        end
    endtask

    // result side: random stalls, and each result checked against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_hold <= 0;
        end else if (o_valid && i_ready) begin
            if (pending_mix.size() == 0) begin
                $error("unexpected result transaction");
                mismatch_count++;
            end else begin
                want_mix = pending_mix.pop_front();
                if (o_data.left_sample !== want_mix.left_sample) begin
                    $error("left_sample: expected %0d, got %0d",
                           want_mix.left_sample, o_data.left_sample);
                    mismatch_count++;
                end
                if (o_data.right_sample !== want_mix.right_sample) begin
                    $error("right_sample: expected %0d, got %0d",
                           want_mix.right_sample, o_data.right_sample);
                    mismatch_count++;
                end
                if (o_data.dma_fetch_address !== want_mix.dma_fetch_address) begin
                    $error("dma_fetch_address: expected %0h, got %0h",
                           want_mix.dma_fetch_address, o_data.dma_fetch_address);
                    mismatch_count++;
                end
                if (o_data.dma_busy !== want_mix.dma_busy) begin
                    $error("dma_busy: expected %0d, got %0d",
                           want_mix.dma_busy, o_data.dma_busy);
                    mismatch_count++;
                end
                if (o_data.dma_irq !== want_mix.dma_irq) begin
                    $error("dma_irq: expected %0d, got %0d",
                           want_mix.dma_irq, o_data.dma_irq);
                    mismatch_count++;
                end
            end
            rx_gap = idle_on ? $urandom_range(0, 3) : 0;
            i_ready <= (rx_gap == 0);
            rx_hold <= (rx_gap == 0) ? 0 : rx_gap - 1;
        end else if (!i_ready) begin
            if (rx_hold == 0) i_ready <= 1'b1;
            else rx_hold <= rx_hold - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (mem_image[a]) mem_image[a] = 8'($urandom);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_tones();
        test_noise();
        test_dma_playback();
        test_random_mix();
        i_valid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_mix.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
src/hsg_pkg.sv
src/hsg_tone.sv
src/handheld_sound_generator_unit.sv
dv/testbench.sv
